// ----- sv/bdlp_pkg.sv -----
// ----------------------------------------------------------------------------
// bdlp_pkg: shared types and per-switch update for the debouncer
// Holds state codes, notice codes, configuration indexes and the one-tick
// update function that every switch lane runs.
// ----------------------------------------------------------------------------
`default_nettype none

package bdlp_pkg;

    // Number of switches and widths of the counters
    localparam int NUM_SW    = 4;
    localparam int CNT_W     = 6;
    localparam int HOLD_W    = 16;
    localparam int TICK_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
    localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASED_LEVEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_SAMPLES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_SAMPLES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_SAMPLES   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_MS        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STUCK_LIMIT    = 3'd5;

    // Reset values of the configuration registers
    localparam logic              RST_RELEASED_LEVEL  = 1'b0;
    localparam logic [CNT_W-1:0]  RST_PRESS_SAMPLES   = 6'd3;
    localparam logic [CNT_W-1:0]  RST_RELEASE_SAMPLES = 6'd3;
    localparam logic [CNT_W-1:0]  RST_LONG_SAMPLES    = 6'd50;
    localparam logic [TICK_W-1:0] RST_TICK_MS         = 8'd20;
    localparam logic [HOLD_W-1:0] RST_STUCK_LIMIT     = 16'd59000;

    // Debounced switch state
    typedef enum logic [1:0] {
        ST_REL = 2'd0,
        ST_PRS = 2'd1,
        ST_LNG = 2'd2
    } t_sw_st;

    // Notice codes shown on the notify outputs
    localparam logic [1:0] NOTE_NONE  = 2'd0;
    localparam logic [1:0] NOTE_SHORT = 2'd1;
    localparam logic [1:0] NOTE_LONG  = 2'd2;

    typedef struct packed {
        logic              released_level;
        logic [CNT_W-1:0]  press_samples;
        logic [CNT_W-1:0]  release_samples;
        logic [CNT_W-1:0]  long_samples;
        logic [TICK_W-1:0] tick_ms;
        logic [HOLD_W-1:0] stuck_limit;
    } t_cfg;

    typedef struct packed {
        t_sw_st            st;
        t_sw_st            prev;
        logic [CNT_W-1:0]  pc;
        logic [CNT_W-1:0]  rc;
        logic [HOLD_W-1:0] hold;
        logic              armed;
        logic [1:0]        notice;
    } t_sw_state;

    typedef struct packed {
        t_sw_state nxt;
        logic      stuck;
    } t_sw_step;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? CNT_MAX : c + CNT_W'(1);
    endfunction

    // One sampling tick of one switch
    function automatic t_sw_step sw_step(input t_sw_state s, input logic pressed,
                                         input t_cfg c);
        t_sw_step          r;
        t_sw_st            st;
        logic [CNT_W-1:0]  pc;
        logic [CNT_W-1:0]  rc;
        logic [HOLD_W-1:0] hold;
        logic [HOLD_W:0]   sum;
        st   = s.st;
        pc   = s.pc;
        rc   = s.rc;
        hold = s.hold;
        sum  = {1'b0, s.hold} + {{(HOLD_W+1-TICK_W){1'b0}}, c.tick_ms};
        r    = '{nxt: s, stuck: 1'b0};

        // state counters
        unique case (s.st)
            ST_PRS: begin
                if (pressed) begin
                    rc = '0;
                    pc = sat_inc(s.pc);
                end else begin
                    rc = sat_inc(s.rc);
                end
                if (pc >= c.long_samples) begin
                    rc = '0;
                    pc = '0;
                    st = ST_LNG;
                end else if (rc >= c.release_samples) begin
                    rc = '0;
                    pc = '0;
                    st = ST_REL;
                end
            end
            ST_LNG: begin
                pc = '0;
                rc = pressed ? '0 : sat_inc(s.rc);
                if (rc >= c.release_samples) begin
                    rc   = '0;
                    st   = ST_REL;
                    hold = '0;
                end else if (s.hold <= c.stuck_limit) begin
                    hold = sum[HOLD_W] ? HOLD_MAX : sum[HOLD_W-1:0];
                end
            end
            default: begin
                rc = '0;
                pc = pressed ? sat_inc(s.pc) : '0;
                if (pc >= c.press_samples) begin
                    pc = '0;
                    st = ST_PRS;
                end
            end
        endcase

        // notice and arming
        priority if (st != s.prev) begin
            if (s.prev == ST_REL && st == ST_PRS) begin
                r.nxt.armed = 1'b1;
            end else if (s.armed && s.prev == ST_PRS && st == ST_REL) begin
                r.nxt.notice = NOTE_SHORT;
                r.nxt.armed  = 1'b0;
            end
            r.nxt.prev = st;
        end else if (s.armed && st == ST_LNG) begin
            r.nxt.notice = NOTE_LONG;
            r.nxt.armed  = 1'b0;
        end else begin
            r.nxt.notice = NOTE_NONE;
        end

        // stuck check clears the hold timer
        if (hold > c.stuck_limit) begin
            r.stuck = 1'b1;
            hold    = '0;
        end

        r.nxt.st   = st;
        r.nxt.pc   = pc;
        r.nxt.rc   = rc;
        r.nxt.hold = hold;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/button_debounce_long_press.sv -----
// ----------------------------------------------------------------------------
// button_debounce_long_press: four-switch debouncer with long-press notice
// Debounces four raw switch bits, reports short and long presses, the
// debounced state of each switch and a stuck flag per switch.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one sampling tick per beat:
//   four raw switch bits. Output channel (o_valid / i_ready) carries one
//   result beat per input beat: notice and debounced state per switch
//   plus the stuck flags.
//   An accepted beat goes through the input register; the per-switch update
//   then writes its result into the result register, which drives o_valid.
//   Throughput is one beat per cycle while the receiver keeps i_ready high;
//   the update of all four switches is one shallow level of counter compare
//   and increment logic.
//   A stalled receiver holds the result register; the input register still
//   takes one more beat, then o_ready drops until the result is taken.
//   Reset clears all switch state to released with no notice and loads the
//   default configuration. Configuration writes (i_cfg_we, i_cfg_index,
//   i_cfg_data) take effect at once and are meant for an idle block.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_long_press (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration write port
    input  wire logic                               i_cfg_we,
    input  wire logic [bdlp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [bdlp_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    // input channel
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [bdlp_pkg::NUM_SW-1:0]        i_raw_levels,
    // output channel
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [1:0]                              o_notify_plus,
    output logic [1:0]                              o_notify_minus,
    output logic [1:0]                              o_notify_standby,
    output logic [1:0]                              o_notify_turbo,
    output logic [1:0]                              o_level_plus,
    output logic [1:0]                              o_level_minus,
    output logic [1:0]                              o_level_standby,
    output logic [1:0]                              o_level_turbo,
    output logic [bdlp_pkg::NUM_SW-1:0]             o_stuck_flags
);

    localparam int NSW = bdlp_pkg::NUM_SW;

    bdlp_pkg::t_cfg      r_cfg;
    bdlp_pkg::t_sw_state r_sw [NSW];
    bdlp_pkg::t_sw_step  n_step [NSW];

    logic                r_in_valid;
    logic [NSW-1:0]      r_raw;
    logic                r_out_valid;
    logic [1:0]          r_notify [NSW];
    logic [1:0]          r_level  [NSW];
    logic [NSW-1:0]      r_stuck;
    logic                advance;

    // handshake: input register feeds result register
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign o_valid = r_out_valid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.released_level  <= bdlp_pkg::RST_RELEASED_LEVEL;
            r_cfg.press_samples   <= bdlp_pkg::RST_PRESS_SAMPLES;
            r_cfg.release_samples <= bdlp_pkg::RST_RELEASE_SAMPLES;
            r_cfg.long_samples    <= bdlp_pkg::RST_LONG_SAMPLES;
            r_cfg.tick_ms         <= bdlp_pkg::RST_TICK_MS;
            r_cfg.stuck_limit     <= bdlp_pkg::RST_STUCK_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bdlp_pkg::CFG_RELEASED_LEVEL:
                    r_cfg.released_level <= i_cfg_data[0];
                bdlp_pkg::CFG_PRESS_SAMPLES:
                    r_cfg.press_samples <= i_cfg_data[bdlp_pkg::CNT_W-1:0];
                bdlp_pkg::CFG_RELEASE_SAMPLES:
                    r_cfg.release_samples <= i_cfg_data[bdlp_pkg::CNT_W-1:0];
                bdlp_pkg::CFG_LONG_SAMPLES:
                    r_cfg.long_samples <= i_cfg_data[bdlp_pkg::CNT_W-1:0];
                bdlp_pkg::CFG_TICK_MS:
                    r_cfg.tick_ms <= i_cfg_data[bdlp_pkg::TICK_W-1:0];
                bdlp_pkg::CFG_STUCK_LIMIT:
                    r_cfg.stuck_limit <= i_cfg_data[bdlp_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // input payload register
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_raw <= i_raw_levels;
        end
    end

    // per-switch update
    always_comb begin
        for (int i = 0; i < NSW; i++) begin
            n_step[i] = bdlp_pkg::sw_step(r_sw[i], r_raw[i] ^ r_cfg.released_level,
                                          r_cfg);
        end
    end

    // switch state, updated once per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NSW; i++) begin
                r_sw[i] <= '{st: bdlp_pkg::ST_REL, prev: bdlp_pkg::ST_REL,
                             pc: '0, rc: '0, hold: '0, armed: 1'b0,
                             notice: bdlp_pkg::NOTE_NONE};
            end
        end else if (advance) begin
            for (int i = 0; i < NSW; i++) begin
                r_sw[i] <= n_step[i].nxt;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            for (int i = 0; i < NSW; i++) begin
                r_notify[i] <= n_step[i].nxt.notice;
                r_level[i]  <= n_step[i].nxt.st;
                r_stuck[i]  <= n_step[i].stuck;
            end
        end
    end

    assign o_notify_plus    = r_notify[0];
    assign o_notify_minus   = r_notify[1];
    assign o_notify_standby = r_notify[2];
    assign o_notify_turbo   = r_notify[3];
    assign o_level_plus     = r_level[0];
    assign o_level_minus    = r_level[1];
    assign o_level_standby  = r_level[2];
    assign o_level_turbo    = r_level[3];
    assign o_stuck_flags    = r_stuck;

endmodule

`default_nettype wire

// ----- test/button_debounce_long_press_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_long_press_tb: self-checking bench for the switch debouncer
// Streams raw switch ticks through the valid/ready input under a series of
// threshold settings (defaults, one-sample, zero, maximum, saturating hold
// timer, fast stuck detection, random). A scoreboard keeps its own model of
// every switch lane and checks each result beat field by field.
// ----------------------------------------------------------------------------
module button_debounce_long_press_tb;

    localparam int CLK_HALF            = 4;
    localparam int WATCHDOG_LIMIT      = 2000;
    localparam int BACKPRESSURE_CYCLES = 120;
    localparam int BACKPRESSURE_AFTER  = 400;
    localparam int MAX_PRINTED         = 50;

    // One result beat: notice and debounced state per lane, plus stuck bits
    typedef struct packed {
        logic [bdlp_pkg::NUM_SW-1:0][1:0] notify;
        logic [bdlp_pkg::NUM_SW-1:0][1:0] level;
        logic [bdlp_pkg::NUM_SW-1:0]      stuck;
    } t_tick_report;

    // ------------------------------------------------------------------------
    // Scoreboard: lane model, configuration copy and queue of due reports
    // ------------------------------------------------------------------------
    class t_debounce_scoreboard;
        logic                        rel_level;
        logic [bdlp_pkg::CNT_W-1:0]  press_n;
        logic [bdlp_pkg::CNT_W-1:0]  release_n;
        logic [bdlp_pkg::CNT_W-1:0]  long_n;
        logic [bdlp_pkg::TICK_W-1:0] tick_ms;
        logic [bdlp_pkg::HOLD_W-1:0] stuck_limit;

        bdlp_pkg::t_sw_st            lane_st   [bdlp_pkg::NUM_SW];
        bdlp_pkg::t_sw_st            lane_prev [bdlp_pkg::NUM_SW];
        logic [bdlp_pkg::CNT_W-1:0]  press_cnt [bdlp_pkg::NUM_SW];
        logic [bdlp_pkg::CNT_W-1:0]  rel_cnt   [bdlp_pkg::NUM_SW];
        logic [bdlp_pkg::HOLD_W-1:0] hold_ms   [bdlp_pkg::NUM_SW];
        bit                          armed     [bdlp_pkg::NUM_SW];
        logic [1:0]                  notice    [bdlp_pkg::NUM_SW];

        t_tick_report      reports_due[$];
        int                mismatches;
        int                beats_checked;

        function new();
            rel_level   = bdlp_pkg::RST_RELEASED_LEVEL;
            press_n     = bdlp_pkg::RST_PRESS_SAMPLES;
            release_n   = bdlp_pkg::RST_RELEASE_SAMPLES;
            long_n      = bdlp_pkg::RST_LONG_SAMPLES;
            tick_ms     = bdlp_pkg::RST_TICK_MS;
            stuck_limit = bdlp_pkg::RST_STUCK_LIMIT;
            for (int k = 0; k < bdlp_pkg::NUM_SW; k++) begin
                lane_st[k]   = bdlp_pkg::ST_REL;
                lane_prev[k] = bdlp_pkg::ST_REL;
                press_cnt[k] = '0;
                rel_cnt[k]   = '0;
                hold_ms[k]   = '0;
                armed[k]     = 1'b0;
                notice[k]    = bdlp_pkg::NOTE_NONE;
            end
            mismatches    = 0;
            beats_checked = 0;
        endfunction

        // only the low bits of each register survive a write
        function void write_reg(logic [bdlp_pkg::CFG_IDX_W-1:0] idx,
                                logic [bdlp_pkg::CFG_DAT_W-1:0] data);
            unique case (idx)
                bdlp_pkg::CFG_RELEASED_LEVEL:  rel_level   = data[0];
                bdlp_pkg::CFG_PRESS_SAMPLES:   press_n     = data[bdlp_pkg::CNT_W-1:0];
                bdlp_pkg::CFG_RELEASE_SAMPLES: release_n   = data[bdlp_pkg::CNT_W-1:0];
                bdlp_pkg::CFG_LONG_SAMPLES:    long_n      = data[bdlp_pkg::CNT_W-1:0];
                bdlp_pkg::CFG_TICK_MS:         tick_ms     = data[bdlp_pkg::TICK_W-1:0];
                bdlp_pkg::CFG_STUCK_LIMIT:     stuck_limit = data[bdlp_pkg::HOLD_W-1:0];
                default: ;
            endcase
        endfunction

        // sample counters stick at their top value
        function logic [bdlp_pkg::CNT_W-1:0] bump(logic [bdlp_pkg::CNT_W-1:0] c);
            return (c == bdlp_pkg::CNT_MAX) ? c
                                            : c + {{(bdlp_pkg::CNT_W-1){1'b0}}, 1'b1};
        endfunction

        // Advance one lane by one tick; returns the stuck bit
        function bit step_lane(int k, bit pressed);
            bdlp_pkg::t_sw_st           st;
            logic [bdlp_pkg::CNT_W-1:0] pc;
            logic [bdlp_pkg::CNT_W-1:0] rc;
            logic [bdlp_pkg::HOLD_W:0]  hold;
            bit                         stuck;
            st    = lane_st[k];
            pc    = press_cnt[k];
            rc    = rel_cnt[k];
            hold  = {1'b0, hold_ms[k]};
            stuck = 1'b0;

            // debounce counters and state moves
            unique case (st)
                bdlp_pkg::ST_PRS: begin
                    if (pressed) begin
                        rc = '0;
                        pc = bump(pc);
                    end else begin
                        rc = bump(rc);
                    end
                    if (pc >= long_n) begin
                        pc = '0;
                        rc = '0;
                        st = bdlp_pkg::ST_LNG;
                    end else if (rc >= release_n) begin
                        pc = '0;
                        rc = '0;
                        st = bdlp_pkg::ST_REL;
                    end
                end
                bdlp_pkg::ST_LNG: begin
                    pc = '0;
                    rc = pressed ? '0 : bump(rc);
                    if (rc >= release_n) begin
                        rc   = '0;
                        st   = bdlp_pkg::ST_REL;
                        hold = '0;
                    end else if (hold <= {1'b0, stuck_limit}) begin
                        hold = hold + {{(bdlp_pkg::HOLD_W+1-bdlp_pkg::TICK_W){1'b0}},
                                       tick_ms};
                        if (hold > {1'b0, bdlp_pkg::HOLD_MAX}) begin
                            hold = {1'b0, bdlp_pkg::HOLD_MAX};
                        end
                    end
                end
                default: begin
                    rc = '0;
                    pc = pressed ? bump(pc) : '0;
                    if (pc >= press_n) begin
                        pc = '0;
                        st = bdlp_pkg::ST_PRS;
                    end
                end
            endcase

            // notice only drops on a tick without a state change
            if (st != lane_prev[k]) begin
                if (lane_prev[k] == bdlp_pkg::ST_REL && st == bdlp_pkg::ST_PRS) begin
                    armed[k] = 1'b1;
                end else if (armed[k] && lane_prev[k] == bdlp_pkg::ST_PRS &&
                             st == bdlp_pkg::ST_REL) begin
                    notice[k] = bdlp_pkg::NOTE_SHORT;
                    armed[k]  = 1'b0;
                end
                lane_prev[k] = st;
            end else if (armed[k] && st == bdlp_pkg::ST_LNG) begin
                notice[k] = bdlp_pkg::NOTE_LONG;
                armed[k]  = 1'b0;
            end else begin
                notice[k] = bdlp_pkg::NOTE_NONE;
            end

            // hold timer past the limit flags stuck and restarts
            if (hold > {1'b0, stuck_limit}) begin
                stuck = 1'b1;
                hold  = '0;
            end

            lane_st[k]   = st;
            press_cnt[k] = pc;
            rel_cnt[k]   = rc;
            hold_ms[k]   = hold[bdlp_pkg::HOLD_W-1:0];
            return stuck;
        endfunction

        // Accepted input beat: run all lanes and queue the report
        function void note_tick(logic [bdlp_pkg::NUM_SW-1:0] raw);
            t_tick_report r;
            for (int k = 0; k < bdlp_pkg::NUM_SW; k++) begin
                r.stuck[k]  = step_lane(k, raw[k] != rel_level);
                r.notify[k] = notice[k];
                r.level[k]  = lane_st[k];
            end
            reports_due.push_back(r);
        endfunction

        function string lane_name(int k);
            unique case (k)
                0:       return "plus";
                1:       return "minus";
                2:       return "standby";
                default: return "turbo";
            endcase
        endfunction

        task report_mismatch(string what, int want, int got);
            mismatches++;
            if (mismatches <= MAX_PRINTED) begin
                $display("MISMATCH beat %0d %s: expected %0d got %0d",
                         beats_checked, what, want, got);
            end
        endtask

        // Accepted result beat: compare with the oldest due report
        task check_report(t_tick_report got);
            t_tick_report want;
            if (reports_due.size() == 0) begin
                report_mismatch("result beat with nothing due", 0, 0);
                beats_checked++;
                return;
            end
            want = reports_due.pop_front();
            for (int k = 0; k < bdlp_pkg::NUM_SW; k++) begin
                if (got.notify[k] !== want.notify[k]) begin
                    report_mismatch({"notify_", lane_name(k)}, int'(want.notify[k]),
                                    int'(got.notify[k]));
                end
                if (got.level[k] !== want.level[k]) begin
                    report_mismatch({"level_", lane_name(k)}, int'(want.level[k]),
                                    int'(got.level[k]));
                end
                if (got.stuck[k] !== want.stuck[k]) begin
                    report_mismatch({"stuck_", lane_name(k)}, int'(want.stuck[k]),
                                    int'(got.stuck[k]));
                end
            end
            beats_checked++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT and its signals
    // ------------------------------------------------------------------------
    logic                           i_clk;
    logic                           i_rst_n      = 1'b0;
    logic                           i_cfg_we     = 1'b0;
    logic [bdlp_pkg::CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [bdlp_pkg::CFG_DAT_W-1:0] i_cfg_data   = '0;
    logic                           i_valid      = 1'b0;
    logic                           o_ready;
    logic [bdlp_pkg::NUM_SW-1:0]    i_raw_levels = '0;
    logic                           o_valid;
    logic                           i_ready      = 1'b0;
    logic [1:0]                     o_notify_plus;
    logic [1:0]                     o_notify_minus;
    logic [1:0]                     o_notify_standby;
    logic [1:0]                     o_notify_turbo;
    logic [1:0]                     o_level_plus;
    logic [1:0]                     o_level_minus;
    logic [1:0]                     o_level_standby;
    logic [1:0]                     o_level_turbo;
    logic [bdlp_pkg::NUM_SW-1:0]    o_stuck_flags;

    button_debounce_long_press dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_raw_levels     (i_raw_levels),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_notify_plus    (o_notify_plus),
        .o_notify_minus   (o_notify_minus),
        .o_notify_standby (o_notify_standby),
        .o_notify_turbo   (o_notify_turbo),
        .o_level_plus     (o_level_plus),
        .o_level_minus    (o_level_minus),
        .o_level_standby  (o_level_standby),
        .o_level_turbo    (o_level_turbo),
        .o_stuck_flags    (o_stuck_flags)
    );

    t_debounce_scoreboard sb = new();

    bit calm = 1'b0;                   // no idling on either side while set
    int run_left [bdlp_pkg::NUM_SW];   // ticks left in the current level run, per lane
    bit held     [bdlp_pkg::NUM_SW];   // pressed level of the current run, per lane
    int stalled_cycles = 0;

    // clock
    initial begin : clock_gen
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    // one input beat, then maybe a random gap
    task automatic send_tick(input logic [bdlp_pkg::NUM_SW-1:0] raw);
        int gap;
        i_valid      <= 1'b1;
        i_raw_levels <= raw;
        @(posedge i_clk iff o_ready);
        sb.note_tick(raw);
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // wait for the block to go idle
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.reports_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // low bits of a setting as a register data word
    function automatic logic [bdlp_pkg::CFG_DAT_W-1:0] cfg_word(input int v);
        return v[bdlp_pkg::CFG_DAT_W-1:0];
    endfunction

    // register write; unused upper data bits carry junk
    task automatic write_reg(input logic [bdlp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bdlp_pkg::CFG_DAT_W-1:0] value,
                             input int width);
        logic [bdlp_pkg::CFG_DAT_W-1:0] junk;
        int unsigned                    rnd;
        rnd  = $urandom;
        junk = rnd[bdlp_pkg::CFG_DAT_W-1:0];
        if (width < bdlp_pkg::CFG_DAT_W) begin
            value = value | (junk & ({bdlp_pkg::CFG_DAT_W{1'b1}} << width));
        end
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        sb.write_reg(idx, value);
    endtask

    task automatic configure(input int rl, input int ps, input int rs, input int lps,
                             input int tick, input int limit);
        drain();
        write_reg(bdlp_pkg::CFG_RELEASED_LEVEL, cfg_word(rl), 1);
        write_reg(bdlp_pkg::CFG_PRESS_SAMPLES, cfg_word(ps), bdlp_pkg::CNT_W);
        write_reg(bdlp_pkg::CFG_RELEASE_SAMPLES, cfg_word(rs), bdlp_pkg::CNT_W);
        write_reg(bdlp_pkg::CFG_LONG_SAMPLES, cfg_word(lps), bdlp_pkg::CNT_W);
        write_reg(bdlp_pkg::CFG_TICK_MS, cfg_word(tick), bdlp_pkg::TICK_W);
        write_reg(bdlp_pkg::CFG_STUCK_LIMIT, cfg_word(limit), bdlp_pkg::HOLD_W);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // length of the next level run: bounces, short presses, long holds
    function automatic int run_length(bit pressed, int extra);
        int pick;
        int len;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            len = $urandom_range(1, 3);
        end else if (!pressed) begin
            len = int'(sb.release_n) + $urandom_range(1, 8);
        end else if (pick < 6) begin
            len = int'(sb.press_n) + $urandom_range(0, int'(sb.long_n));
        end else begin
            len = int'(sb.press_n) + int'(sb.long_n) + $urandom_range(extra / 2, extra);
        end
        return (len < 1) ? 1 : len;
    endfunction

    // press/release runs per lane with optional noise flips
    task automatic run_phase(input int n_ticks, input int extra, input int noise_pct);
        logic [bdlp_pkg::NUM_SW-1:0] raw;
        bit                          p;
        for (int t = 0; t < n_ticks; t++) begin
            for (int k = 0; k < bdlp_pkg::NUM_SW; k++) begin
                if (run_left[k] == 0) begin
                    held[k]     = !held[k];
                    run_left[k] = run_length(held[k], extra);
                end
                run_left[k]--;
                p = held[k];
                if ($urandom_range(0, 99) < noise_pct) begin
                    p = !p;
                end
                raw[k] = p ^ sb.rel_level;
            end
            send_tick(raw);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result sink with random stalls and one long hold-off
    // ------------------------------------------------------------------------
    initial begin : result_sink
        t_tick_report got;
        bit           squeezed;
        squeezed = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!squeezed && sb.beats_checked >= BACKPRESSURE_AFTER) begin
                squeezed = 1'b1;
                i_ready <= 1'b0;
                repeat (BACKPRESSURE_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk iff o_valid);
            got.notify = {o_notify_turbo, o_notify_standby, o_notify_minus, o_notify_plus};
            got.level  = {o_level_turbo, o_level_standby, o_level_minus, o_level_plus};
            got.stuck  = o_stuck_flags;
            sb.check_report(got);
        end
    end

    // watchdog: cycles without any beat on either channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("button_debounce_long_press verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [bdlp_pkg::NUM_SW-1:0] warmup [24] = '{
            4'h0, 4'hF, 4'hF, 4'hF, 4'h0, 4'h0, 4'h0, 4'h0,
            4'h1, 4'h2, 4'h4, 4'h8, 4'h5, 4'h5, 4'h5, 4'hA,
            4'hA, 4'hA, 4'h0, 4'h0, 4'h0, 4'hF, 4'h0, 4'h0
        };
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: all-on/all-off, single bits, short presses
        foreach (warmup[j]) begin
            send_tick(warmup[j]);
        end

        // one-sample thresholds, released level high, stuck on every long tick
        configure(1, 1, 1, 1, 1, 0);
        run_phase(100, 6, 5);

        // zero thresholds, back-to-back beats
        configure(0, 0, 0, 0, 255, 65535);
        calm = 1'b1;
        run_phase(80, 6, 5);
        calm = 1'b0;

        // hold timer saturates, never flags stuck
        configure(0, 2, 2, 2, 255, 65535);
        run_phase(320, 300, 3);

        // maximum sample thresholds, clean presses
        configure(1, 63, 63, 63, 200, 65000);
        run_phase(250, 40, 0);

        // fast stuck detection
        configure($urandom_range(0, 1), 3, 2, 5, 255, 1000);
        run_phase(150, 20, 5);

        // random settings, heavy noise
        configure($urandom_range(0, 1), $urandom_range(1, 8), $urandom_range(1, 8),
                  $urandom_range(1, 20), $urandom_range(1, 255), $urandom_range(0, 3000));
        run_phase(80, 10, 40);

        // random settings, no idling to the end
        configure($urandom_range(0, 1), $urandom_range(1, 8), $urandom_range(1, 8),
                  $urandom_range(1, 20), $urandom_range(1, 255), $urandom_range(0, 3000));
        calm = 1'b1;
        run_phase(150, 10, 8);

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.reports_due.size() == 0) begin
            $display("button_debounce_long_press verification clean");
        end else begin
            $display("button_debounce_long_press verification failed");
        end
        $finish;
    end

endmodule
